### hdl/sprq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprq_pkg: shared types and codes for the stable priority ring queue
// Request, status and register codes, field widths and the control FSM states.
// ----------------------------------------------------------------------------
package sprq_pkg;

  // fixed field widths of the ports
  localparam int REQ_W      = 2;
  localparam int PRI_PORT_W = 8;
  localparam int PAY_PORT_W = 32;
  localparam int STATUS_W   = 2;
  localparam int FILL_W     = 5;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_DEQUEUE = 2'd1,
    REQ_PEEK    = 2'd2,
    REQ_FLUSH   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY = 1'd0,
    REG_MODE     = 1'd1
  } cfg_reg_t;

  // IDLE: take a request; READ: head entry lands; SCAN: backward insert scan;
  // PUT: new entry goes to the head slot; EMIT: hand result to the out register
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_PUT,
    S_EMIT
  } state_t;

endpackage : sprq_pkg
`default_nettype wire

### hdl/stable_priority_ring_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_ring_queue_top: ring-buffer queue with stable priority insert
// Entries (priority, payload) live in one synchronous RAM. Requests enqueue,
// dequeue, peek or flush; each request yields exactly one result beat.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Beat contents
//  -------  ---------  -----------------  -------------------------------------
//  in_*     input      in_valid/in_stall  req_type, entry_priority, payload
//  out_*    output     out_valid/out_stall status, priority, payload, fill,
//                                         empty and full flags
//  cfg_*    input      cfg_we             register index and data, no stall
//
//  Steps: flush, FIFO enqueue and error requests go from accept straight to
//  EMIT; dequeue and peek pass through READ first (one RAM read). A
//  priority-mode enqueue passes through SCAN once per entry that the backward
//  scan visits (1..fill of them), with one RAM read and one RAM write per entry
//  through the single read port and single write port of the entry RAM, and
//  also through PUT when the scan runs down to the head.
//  One request is in flight at a time; in_stall is high while it is worked.
//  Reset (rst_n low, synchronous) clears pointers, count, FSM and registers;
//  the entry RAM is not cleared since only counted slots are ever read.
//  A stalled result beat holds in the output register; the next request may
//  be accepted meanwhile and waits in its final step for the register.
//
module stable_priority_ring_queue_top
  import sprq_pkg::*;
#(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_BITS  = 32,
  parameter int PRIORITY_BITS = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // request channel
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire [REQ_W-1:0]       in_req_type,
  input  wire [PRI_PORT_W-1:0]  in_entry_priority,
  input  wire [PAY_PORT_W-1:0]  in_entry_payload,
  // result channel
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [PRI_PORT_W-1:0] out_priority,
  output logic [PAY_PORT_W-1:0] out_payload,
  output logic [FILL_W-1:0]     out_fill_after,
  output logic                  out_is_empty,
  output logic                  out_is_full,
  // configuration
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW      = $clog2(DEPTH);       // slot index
  localparam int CW      = $clog2(DEPTH + 1);   // count / capacity
  localparam int EW      = PRIORITY_BITS + PAYLOAD_BITS;
  localparam int CAP_RST = (DEPTH < 16) ? DEPTH : 16;

  // --------------------------------------------------------------------------
  // ring helpers
  // --------------------------------------------------------------------------
  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i,
                                              input logic [CW-1:0] cap);
    logic [CW-1:0] inc;
    begin
      inc = CW'(i) + CW'(1);
      ring_next = (inc >= cap) ? '0 : IW'(inc);
    end
  endfunction

  function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i,
                                              input logic [CW-1:0] cap);
    begin
      ring_prev = (i == '0) ? IW'(cap - CW'(1)) : i - IW'(1);
    end
  endfunction

  // capacity written is clamped into 1..DEPTH
  function automatic logic [CW-1:0] cap_clamp(input logic [CFG_DATA_W-1:0] v);
    begin
      if (v == '0) begin
        cap_clamp = CW'(1);
      end else if (32'(v) > DEPTH) begin
        cap_clamp = CW'(DEPTH);
      end else begin
        cap_clamp = CW'(v);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // entry RAM: one write port, one read port, registered read data
  // entry layout {priority, payload}
  // --------------------------------------------------------------------------
  logic [EW-1:0] store_r [DEPTH];
  logic [EW-1:0] rd_data_r;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  logic [PRIORITY_BITS-1:0] rd_pri;
  logic [PAYLOAD_BITS-1:0]  rd_pay;
  assign rd_pri = rd_data_r[EW-1:PAYLOAD_BITS];
  assign rd_pay = rd_data_r[PAYLOAD_BITS-1:0];

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  state_t                   state_r, state_nxt;
  logic [IW-1:0]            head_r, head_nxt;
  logic [IW-1:0]            tail_r, tail_nxt;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic [CW-1:0]            cap_r, cap_nxt;
  logic                     mode_r, mode_nxt;
  logic [IW-1:0]            pos_r, pos_nxt;          // scan position
  logic [PRIORITY_BITS-1:0] new_pri_r, new_pri_nxt;  // entry being inserted
  logic [PAYLOAD_BITS-1:0]  new_pay_r, new_pay_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic [PRI_PORT_W-1:0]    res_pri_r, res_pri_nxt;
  logic [PAY_PORT_W-1:0]    res_pay_r, res_pay_nxt;

  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [PRI_PORT_W-1:0]    out_pri_r, out_pri_nxt;
  logic [PAY_PORT_W-1:0]    out_pay_r, out_pay_nxt;
  logic [FILL_W-1:0]        out_fill_r, out_fill_nxt;
  logic                     out_empty_r, out_empty_nxt;
  logic                     out_full_r, out_full_nxt;

  logic                     accept;
  logic [PRIORITY_BITS-1:0] in_pri;
  logic [PAYLOAD_BITS-1:0]  in_pay;
  logic [EW-1:0]            new_entry;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_pri    = PRIORITY_BITS'(in_entry_priority);
  assign in_pay    = PAYLOAD_BITS'(in_entry_payload);
  assign new_entry = {new_pri_r, new_pay_r};

  // --------------------------------------------------------------------------
  // next state and RAM control
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    cap_nxt        = cap_r;
    mode_nxt       = mode_r;
    pos_nxt        = pos_r;
    new_pri_nxt    = new_pri_r;
    new_pay_nxt    = new_pay_r;
    res_status_nxt = res_status_r;
    res_pri_nxt    = res_pri_r;
    res_pay_nxt    = res_pay_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_pri_nxt    = out_pri_r;
    out_pay_nxt    = out_pay_r;
    out_fill_nxt   = out_fill_r;
    out_empty_nxt  = out_empty_r;
    out_full_nxt   = out_full_r;

    wr_en   = 1'b0;
    wr_addr = tail_r;
    wr_data = {in_pri, in_pay};
    rd_en   = 1'b0;
    rd_addr = head_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = STATUS_OK;
          res_pri_nxt    = '0;
          res_pay_nxt    = '0;
          state_nxt      = S_EMIT;
          case (in_req_type)
            REQ_ENQUEUE: begin
              if (fill_r >= cap_r) begin
                res_status_nxt = STATUS_FULL;
              end else begin
                tail_nxt = ring_next(tail_r, cap_r);
                fill_nxt = fill_r + CW'(1);
                if (mode_r && (fill_r != '0)) begin
                  // scan backward from the slot before the tail
                  new_pri_nxt = in_pri;
                  new_pay_nxt = in_pay;
                  pos_nxt     = ring_prev(tail_r, cap_r);
                  rd_en       = 1'b1;
                  rd_addr     = pos_nxt;
                  state_nxt   = S_SCAN;
                end else begin
                  wr_en = 1'b1;
                end
              end
            end
            REQ_DEQUEUE, REQ_PEEK: begin
              if (fill_r == '0) begin
                res_status_nxt = STATUS_EMPTY;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_READ;
                if (in_req_type == REQ_DEQUEUE) begin
                  head_nxt = ring_next(head_r, cap_r);
                  fill_nxt = fill_r - CW'(1);
                end
              end
            end
            REQ_FLUSH: begin
              head_nxt = '0;
              tail_nxt = '0;
              fill_nxt = '0;
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end

      S_READ: begin
        res_pri_nxt = PRI_PORT_W'(rd_pri);
        res_pay_nxt = PAY_PORT_W'(rd_pay);
        state_nxt   = S_EMIT;
      end

      S_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = ring_next(pos_r, cap_r);
        if (rd_pri >= new_pri_r) begin
          // stop: insert right behind the entry of equal or higher priority
          wr_data   = new_entry;
          state_nxt = S_EMIT;
        end else begin
          // move this entry one slot toward the tail
          wr_data = rd_data_r;
          if (pos_r == head_r) begin
            state_nxt = S_PUT;
          end else begin
            pos_nxt = ring_prev(pos_r, cap_r);
            rd_en   = 1'b1;
            rd_addr = pos_nxt;
          end
        end
      end

      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = head_r;
        wr_data   = new_entry;
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pri_nxt    = res_pri_r;
          out_pay_nxt    = res_pay_r;
          out_fill_nxt   = FILL_W'(fill_r);
          out_empty_nxt  = (fill_r == '0);
          out_full_nxt   = (fill_r >= cap_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // register writes; a capacity write also empties the ring
    if (cfg_we) begin
      case (cfg_index)
        REG_CAPACITY: begin
          cap_nxt  = cap_clamp(cfg_data);
          head_nxt = '0;
          tail_nxt = '0;
          fill_nxt = '0;
        end
        REG_MODE: begin
          mode_nxt = cfg_data[0];
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      cap_r       <= CW'(CAP_RST);
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      cap_r       <= cap_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    new_pri_r    <= new_pri_nxt;
    new_pay_r    <= new_pay_nxt;
    res_status_r <= res_status_nxt;
    res_pri_r    <= res_pri_nxt;
    res_pay_r    <= res_pay_nxt;
    out_status_r <= out_status_nxt;
    out_pri_r    <= out_pri_nxt;
    out_pay_r    <= out_pay_nxt;
    out_fill_r   <= out_fill_nxt;
    out_empty_r  <= out_empty_nxt;
    out_full_r   <= out_full_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_priority   = out_pri_r;
  assign out_payload    = out_pay_r;
  assign out_fill_after = out_fill_r;
  assign out_is_empty   = out_empty_r;
  assign out_is_full    = out_full_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // count never exceeds the ring size in use
  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cap_r)
    else $error("fill count above capacity");

  // pointers stay inside the active ring
  a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(head_r) < cap_r) && (CW'(tail_r) < cap_r))
    else $error("ring pointer outside capacity");

  // a new result beat only comes out of the emit step
  a_beat_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result beat raised outside emit step");

  // a backward scan only runs on a non-empty ring
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (fill_r > CW'(1)))
    else $error("insert scan on a ring without entries");

endmodule : stable_priority_ring_queue_top
`default_nettype wire
